FILE: hdl/bir_pkg.sv
// shared constants and types of the bilinear resize block
package bir_pkg;

    // fixed geometry and arithmetic precision
    localparam int FRAC_BITS   = 16;
    localparam int MAX_SRC_DIM = 256;
    localparam int MAX_DST_DIM = 4096;

    // field widths
    localparam int PIX_W    = 8;
    localparam int SRC_AW   = $clog2(MAX_SRC_DIM);
    localparam int DST_AW   = 12;
    localparam int SSIZE_W  = 9;
    localparam int DSIZE_W  = 13;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 13;

    // coordinate mapping datapath
    localparam int PROD_W   = SRC_AW + DST_AW;
    localparam int DIVD_W   = PROD_W + FRAC_BITS;
    localparam int QUO_W    = SRC_AW + FRAC_BITS;

    // blend datapath
    localparam int WGT_W    = FRAC_BITS + 1;
    localparam int WPROD_W  = 2 * FRAC_BITS + 1;
    localparam int ACC_W    = 2 * FRAC_BITS + 9;

    // source frame banking by row and column parity
    localparam int NUM_BANKS  = 4;
    localparam int BANK_AW    = 2 * (SRC_AW - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // item kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_REQ  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_DST_WIDTH,
        REG_DST_HEIGHT
    } cfg_reg_t;

    // effective sizes after clamping
    typedef struct packed {
        logic [SSIZE_W-1:0] src_w;
        logic [SSIZE_W-1:0] src_h;
        logic [DSIZE_W-1:0] dst_w;
        logic [DSIZE_W-1:0] dst_h;
    } bir_cfg_t;

    // classified item passed from front to back
    typedef struct packed {
        logic                 is_req;
        logic [SRC_AW-1:0]    x1;
        logic [SRC_AW-1:0]    x2;
        logic [SRC_AW-1:0]    y1;
        logic [SRC_AW-1:0]    y2;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [PIX_W-1:0]     pixel;
        logic [DST_AW-1:0]    col;
        logic [DST_AW-1:0]    row;
    } bir_item_t;

endpackage

FILE: hdl/bir_ram.sv
// generic simple dual port ram with registered read
module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/bir_div.sv
// pipelined restoring divider, one quotient bit per stage
module bir_div #(
    parameter int NW = 36,
    parameter int QW = 24,
    parameter int TW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [NW-QW-1:0] divisor,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [QW-1:0] quotient,
    output logic [TW-1:0] out_tag
);

    localparam int DW = NW - QW;

    logic          v_reg   [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [DW-1:0] dsr_reg [QW];
    logic [TW-1:0] tag_reg [QW];

    // quotient fits QW bits as the dividend stays below divisor << QW
    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic          v_i;
        logic [DW-1:0] rem_i;
        logic [QW-1:0] low_i;
        logic [DW-1:0] d_i;
        logic [TW-1:0] t_i;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign v_i   = in_valid;
            assign rem_i = dividend[NW-1:QW];
            assign low_i = dividend[QW-1:0];
            assign d_i   = divisor;
            assign t_i   = in_tag;
        end
        else
        begin : g_next
            assign v_i   = v_reg[k-1];
            assign rem_i = rem_reg[k-1];
            assign low_i = low_reg[k-1];
            assign d_i   = dsr_reg[k-1];
            assign t_i   = tag_reg[k-1];
        end

        // trial subtract of the next dividend bit
        assign trial = {rem_i, low_i[QW-1]};
        assign diff  = trial - {1'b0, d_i};
        assign ge    = (trial >= {1'b0, d_i});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_i;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_reg[k] <= {low_i[QW-2:0], ge};
            dsr_reg[k] <= d_i;
            tag_reg[k] <= t_i;
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quotient  = low_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

FILE: hdl/bir_front.sv
// front end: captures transactions and maps destination to source coordinates
module bir_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              mode,
    input  logic [bir_pkg::SRC_AW-1:0]        src_col,
    input  logic [bir_pkg::SRC_AW-1:0]        src_row,
    input  logic [bir_pkg::PIX_W-1:0]         src_pixel,
    input  logic [bir_pkg::DST_AW-1:0]        dst_col,
    input  logic [bir_pkg::DST_AW-1:0]        dst_row,
    input  bir_pkg::bir_cfg_t                 cfg,
    output logic                              item_valid,
    output bir_pkg::bir_item_t                item
);

    localparam int SA = bir_pkg::SRC_AW;
    localparam int DA = bir_pkg::DST_AW;
    localparam int F  = bir_pkg::FRAC_BITS;
    localparam int PW = bir_pkg::PIX_W;
    localparam int XTW = 1 + DA + SA + PW + 1;
    localparam int YTW = DA + SA + 1;

    logic          v0_reg;
    logic          mode_reg;
    logic [SA-1:0] scol_reg;
    logic [SA-1:0] srow_reg;
    logic [PW-1:0] spix_reg;
    logic [DA-1:0] dcol_reg;
    logic [DA-1:0] drow_reg;

    logic [bir_pkg::DSIZE_W-1:0] dlast_x, dlast_y;
    logic [bir_pkg::SSIZE_W-1:0] slast_x, slast_y;
    logic [DA-1:0]               dcx, dcy;
    logic [bir_pkg::PROD_W-1:0]  prod_x, prod_y;
    logic                        zero_x, zero_y;

    logic                        vx, vy;
    logic [bir_pkg::QUO_W-1:0]   qx, qy;
    logic [XTW-1:0]              xtag;
    logic [YTW-1:0]              ytag;

    logic                        t_mode;
    logic [DA-1:0]               t_dcol, t_drow;
    logic [SA-1:0]               t_scol, t_srow;
    logic [PW-1:0]               t_spix;
    logic                        t_zx, t_zy;
    logic [SA-1:0]               x1, y1, x2, y2, x1_raw, y1_raw;
    logic [F-1:0]                fx, fy;

    logic                        item_valid_reg;
    bir_pkg::bir_item_t          item_reg, item_next;

    // input capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode;
        scol_reg <= src_col;
        srow_reg <= src_row;
        spix_reg <= src_pixel;
        dcol_reg <= dst_col;
        drow_reg <= dst_row;
    end

    // clamp request to destination size and form (src-1)*d
    always_comb
    begin
        dlast_x = cfg.dst_w - 13'd1;
        dlast_y = cfg.dst_h - 13'd1;
        slast_x = cfg.src_w - 9'd1;
        slast_y = cfg.src_h - 9'd1;
        dcx = ({1'b0, dcol_reg} > dlast_x) ? dlast_x[DA-1:0] : dcol_reg;
        dcy = ({1'b0, drow_reg} > dlast_y) ? dlast_y[DA-1:0] : drow_reg;
        prod_x = bir_pkg::PROD_W'(slast_x[SA-1:0]) * bir_pkg::PROD_W'(dcx);
        prod_y = bir_pkg::PROD_W'(slast_y[SA-1:0]) * bir_pkg::PROD_W'(dcy);
        zero_x = (cfg.dst_w == 13'd1);
        zero_y = (cfg.dst_h == 13'd1);
    end

    // column divider carries the transaction kind, the column fields and the source pixel
    bir_div #(
        .NW(bir_pkg::DIVD_W),
        .QW(bir_pkg::QUO_W),
        .TW(XTW)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v0_reg),
        .dividend ({prod_x, {F{1'b0}}}),
        .divisor  (dlast_x[DA-1:0]),
        .in_tag   ({mode_reg, dcol_reg, scol_reg, spix_reg, zero_x}),
        .out_valid(vx),
        .quotient (qx),
        .out_tag  (xtag)
    );

    // row divider carries the row fields
    bir_div #(
        .NW(bir_pkg::DIVD_W),
        .QW(bir_pkg::QUO_W),
        .TW(YTW)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v0_reg),
        .dividend ({prod_y, {F{1'b0}}}),
        .divisor  (dlast_y[DA-1:0]),
        .in_tag   ({drow_reg, srow_reg, zero_y}),
        .out_valid(vy),
        .quotient (qy),
        .out_tag  (ytag)
    );

    // split coordinates into integer and fraction, clamp neighbours to the edge
    always_comb
    begin
        {t_mode, t_dcol, t_scol, t_spix, t_zx} = xtag;
        {t_drow, t_srow, t_zy}                 = ytag;
        x1_raw = t_zx ? '0 : qx[bir_pkg::QUO_W-1:F];
        y1_raw = t_zy ? '0 : qy[bir_pkg::QUO_W-1:F];
        fx     = t_zx ? '0 : qx[F-1:0];
        fy     = t_zy ? '0 : qy[F-1:0];
        x1 = (x1_raw > slast_x[SA-1:0]) ? slast_x[SA-1:0] : x1_raw;
        y1 = (y1_raw > slast_y[SA-1:0]) ? slast_y[SA-1:0] : y1_raw;
        x2 = ((bir_pkg::SSIZE_W'(x1) + 9'd1) >= cfg.src_w) ? slast_x[SA-1:0] : x1 + 1'b1;
        y2 = ((bir_pkg::SSIZE_W'(y1) + 9'd1) >= cfg.src_h) ? slast_y[SA-1:0] : y1 + 1'b1;

        item_next.is_req = (t_mode == bir_pkg::MODE_REQ);
        item_next.x1     = item_next.is_req ? x1 : t_scol;
        item_next.y1     = item_next.is_req ? y1 : t_srow;
        item_next.x2     = x2;
        item_next.y2     = y2;
        item_next.fx     = fx;
        item_next.fy     = fy;
        item_next.pixel  = t_spix;
        item_next.col    = t_dcol;
        item_next.row    = t_drow;
    end

    // classified item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= vx;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    // both dividers run in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n) vx == vy)
        else $error("column and row dividers out of step");

endmodule

FILE: hdl/bir_queue.sv
// short queue between front and back ends
module bir_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bir_pkg::bir_item_t push_item,
    output logic               pop_valid,
    output bir_pkg::bir_item_t pop_item
);

    localparam int QW = bir_pkg::QPTR_W;

    bir_pkg::bir_item_t mem_reg [bir_pkg::QUEUE_DEPTH];
    logic [QW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QW:0]        count_reg, count_next;
    logic               pop;

    // the back end drains one entry whenever one is waiting
    assign pop       = (count_reg != '0);
    assign pop_valid = pop;
    assign pop_item  = mem_reg[rd_ptr_reg];

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QW+1)'(push) - (QW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != (QW+1)'(bir_pkg::QUEUE_DEPTH)))
        else $error("queue overflow");

endmodule

FILE: hdl/bir_back.sv
// back end: banked source frame and bilinear blend pipeline
module bir_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  bir_pkg::bir_item_t            in_item,
    output logic                          out_valid,
    output logic [bir_pkg::PIX_W-1:0]     out_pixel,
    output logic [bir_pkg::DST_AW-1:0]    out_col,
    output logic [bir_pkg::DST_AW-1:0]    out_row
);

    localparam int F   = bir_pkg::FRAC_BITS;
    localparam int SA  = bir_pkg::SRC_AW;
    localparam int BA  = bir_pkg::BANK_AW;
    localparam int PW  = bir_pkg::PIX_W;
    localparam int WW  = bir_pkg::WGT_W;
    localparam int WPW = bir_pkg::WPROD_W;
    localparam int AW  = bir_pkg::ACC_W;
    localparam int DA  = bir_pkg::DST_AW;

    logic [PW-1:0] rdata [bir_pkg::NUM_BANKS];
    logic          req_in;

    // stage 1 registers
    logic          v1_reg;
    logic [WW-1:0] wx0_reg, wx1_reg, wy0_reg, wy1_reg;
    logic          px1_reg, px2_reg, py1_reg, py2_reg;
    logic [DA-1:0] col1_reg, row1_reg;

    // stage 2 registers
    logic           v2_reg;
    logic [WPW-1:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [PW-1:0]  pa_reg, pb_reg, pc_reg, pd_reg;
    logic [DA-1:0]  col2_reg, row2_reg;
    logic [2*WW-1:0] wa_full, wb_full, wc_full, wd_full;

    // stage 3 registers
    logic          v3_reg;
    logic [AW-1:0] ma_reg, mb_reg, mc_reg, md_reg;
    logic [DA-1:0] col3_reg, row3_reg;

    // output registers
    logic          out_valid_reg;
    logic [PW-1:0] out_pixel_reg;
    logic [DA-1:0] out_col_reg, out_row_reg;

    logic [AW-1:0] acc;
    logic [AW-2*F-1:0] rounded;
    logic [PW-1:0] pixel_next;
    logic [WW-1:0] one_w;

    assign req_in = in_valid && in_item.is_req;
    assign one_w  = {1'b1, {F{1'b0}}};

    // one bank per row and column parity, so all four neighbours read at once
    for (genvar b = 0; b < bir_pkg::NUM_BANKS; b++)
    begin : g_bank
        logic [SA-1:0] rsel, csel;
        logic          we;

        assign rsel = (in_item.y1[0] == b[1]) ? in_item.y1 : in_item.y2;
        assign csel = (in_item.x1[0] == b[0]) ? in_item.x1 : in_item.x2;
        assign we   = in_valid && !in_item.is_req
                      && (in_item.y1[0] == b[1]) && (in_item.x1[0] == b[0]);

        bir_ram #(
            .WIDTH(PW),
            .DEPTH(bir_pkg::BANK_DEPTH)
        ) u_ram (
            .clk  (clk),
            .we   (we),
            .waddr({in_item.y1[SA-1:1], in_item.x1[SA-1:1]}),
            .wdata(in_item.pixel),
            .raddr({rsel[SA-1:1], csel[SA-1:1]}),
            .rdata(rdata[b])
        );
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= req_in;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // stage 1: axis weights alongside the memory read
    always_ff @(posedge clk)
    begin
        wx0_reg  <= one_w - {1'b0, in_item.fx};
        wx1_reg  <= {1'b0, in_item.fx};
        wy0_reg  <= one_w - {1'b0, in_item.fy};
        wy1_reg  <= {1'b0, in_item.fy};
        px1_reg  <= in_item.x1[0];
        px2_reg  <= in_item.x2[0];
        py1_reg  <= in_item.y1[0];
        py2_reg  <= in_item.y2[0];
        col1_reg <= in_item.col;
        row1_reg <= in_item.row;
    end

    // stage 2: corner weights and neighbour selection
    assign wa_full = wx0_reg * wy0_reg;
    assign wb_full = wx1_reg * wy0_reg;
    assign wc_full = wx0_reg * wy1_reg;
    assign wd_full = wx1_reg * wy1_reg;

    always_ff @(posedge clk)
    begin
        wa_reg   <= wa_full[WPW-1:0];
        wb_reg   <= wb_full[WPW-1:0];
        wc_reg   <= wc_full[WPW-1:0];
        wd_reg   <= wd_full[WPW-1:0];
        pa_reg   <= rdata[{py1_reg, px1_reg}];
        pb_reg   <= rdata[{py1_reg, px2_reg}];
        pc_reg   <= rdata[{py2_reg, px1_reg}];
        pd_reg   <= rdata[{py2_reg, px2_reg}];
        col2_reg <= col1_reg;
        row2_reg <= row1_reg;
    end

    // stage 3: weighted neighbours
    always_ff @(posedge clk)
    begin
        ma_reg   <= AW'(wa_reg) * AW'(pa_reg);
        mb_reg   <= AW'(wb_reg) * AW'(pb_reg);
        mc_reg   <= AW'(wc_reg) * AW'(pc_reg);
        md_reg   <= AW'(wd_reg) * AW'(pd_reg);
        col3_reg <= col2_reg;
        row3_reg <= row2_reg;
    end

    // sum, round half up and saturate
    always_comb
    begin
        acc = ma_reg + mb_reg + mc_reg + md_reg + (AW'(1) << (2 * F - 1));
        rounded = acc[AW-1:2*F];
        pixel_next = (rounded > (AW-2*F)'(255)) ? 8'd255 : rounded[PW-1:0];
    end

    always_ff @(posedge clk)
    begin
        out_pixel_reg <= pixel_next;
        out_col_reg   <= col3_reg;
        out_row_reg   <= row3_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;

    a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_in |-> ##4 out_valid_reg)
        else $error("request lost in blend pipeline");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !req_in |-> ##4 !out_valid_reg)
        else $error("result without a request");

endmodule

FILE: hdl/bilinear_image_resize.sv
// top level of the bilinear image resize block
// a request passes through input capture, the coordinate dividers, the queue and the blend pipeline
// throughput: one transaction per clock, loads and requests alike; busy stays low
// results come on a one-cycle strobe that the receiver cannot hold off
// reset clears all control state and sets every size register to 256; the frame is
//   undefined until loaded
module bilinear_image_resize (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           mode,
    input  logic [bir_pkg::SRC_AW-1:0]     src_col,
    input  logic [bir_pkg::SRC_AW-1:0]     src_row,
    input  logic [bir_pkg::PIX_W-1:0]      src_pixel,
    input  logic [bir_pkg::DST_AW-1:0]     dst_col,
    input  logic [bir_pkg::DST_AW-1:0]     dst_row,
    input  logic                           cfg_we,
    input  logic [bir_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [bir_pkg::CFG_DW-1:0]     cfg_data,
    output logic                           out_valid,
    output logic [bir_pkg::PIX_W-1:0]      out_pixel,
    output logic [bir_pkg::DST_AW-1:0]     out_col,
    output logic [bir_pkg::DST_AW-1:0]     out_row
);

    localparam int SW = bir_pkg::SSIZE_W;
    localparam int DW = bir_pkg::DSIZE_W;

    logic [SW-1:0] src_width_reg, src_height_reg;
    logic [DW-1:0] dst_width_reg, dst_height_reg;
    bir_pkg::bir_cfg_t  cfg;
    logic               accept;
    logic               fe_valid;
    bir_pkg::bir_item_t fe_item;
    logic               be_valid;
    bir_pkg::bir_item_t be_item;

    // the pipeline takes a transaction every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SW'(256);
            src_height_reg <= SW'(256);
            dst_width_reg  <= DW'(256);
            dst_height_reg <= DW'(256);
        end
        else if (cfg_we)
        begin
            case (bir_pkg::cfg_reg_t'(cfg_index))
                bir_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SW-1:0];
                bir_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[SW-1:0];
                bir_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data[DW-1:0];
                bir_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // zero sizes count as one, oversized ones saturate
    always_comb
    begin
        cfg.src_w = (src_width_reg == '0) ? SW'(1) :
                    (src_width_reg > SW'(bir_pkg::MAX_SRC_DIM)) ?
                    SW'(bir_pkg::MAX_SRC_DIM) : src_width_reg;
        cfg.src_h = (src_height_reg == '0) ? SW'(1) :
                    (src_height_reg > SW'(bir_pkg::MAX_SRC_DIM)) ?
                    SW'(bir_pkg::MAX_SRC_DIM) : src_height_reg;
        cfg.dst_w = (dst_width_reg == '0) ? DW'(1) :
                    (dst_width_reg > DW'(bir_pkg::MAX_DST_DIM)) ?
                    DW'(bir_pkg::MAX_DST_DIM) : dst_width_reg;
        cfg.dst_h = (dst_height_reg == '0) ? DW'(1) :
                    (dst_height_reg > DW'(bir_pkg::MAX_DST_DIM)) ?
                    DW'(bir_pkg::MAX_DST_DIM) : dst_height_reg;
    end

    // front end
    bir_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .mode      (mode),
        .src_col   (src_col),
        .src_row   (src_row),
        .src_pixel (src_pixel),
        .dst_col   (dst_col),
        .dst_row   (dst_row),
        .cfg       (cfg),
        .item_valid(fe_valid),
        .item      (fe_item)
    );

    // queue between the two halves
    bir_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fe_valid),
        .push_item(fe_item),
        .pop_valid(be_valid),
        .pop_item (be_item)
    );

    // back end
    bir_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (be_valid),
        .in_item  (be_item),
        .out_valid(out_valid),
        .out_pixel(out_pixel),
        .out_col  (out_col),
        .out_row  (out_row)
    );

endmodule

FILE: bench/bilinear_image_resize_tb.sv
// self-checking testbench of the bilinear image resize block
module bilinear_image_resize_tb;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 900000;

    localparam int SRC_AW      = bir_pkg::SRC_AW;
    localparam int PIX_W       = bir_pkg::PIX_W;
    localparam int DST_AW      = bir_pkg::DST_AW;
    localparam int CFG_DW      = bir_pkg::CFG_DW;
    localparam int FRAC_BITS   = bir_pkg::FRAC_BITS;
    localparam int MAX_SRC_DIM = bir_pkg::MAX_SRC_DIM;
    localparam int MAX_DST_DIM = bir_pkg::MAX_DST_DIM;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 mode;
    logic [SRC_AW-1:0]    src_col;
    logic [SRC_AW-1:0]    src_row;
    logic [PIX_W-1:0]     src_pixel;
    logic [DST_AW-1:0]    dst_col;
    logic [DST_AW-1:0]    dst_row;
    logic                 cfg_we;
    bir_pkg::cfg_reg_t    cfg_index;
    logic [CFG_DW-1:0]    cfg_data;
    logic                 out_valid;
    logic [PIX_W-1:0]     out_pixel;
    logic [DST_AW-1:0]    out_col;
    logic [DST_AW-1:0]    out_row;

    typedef struct {
        logic [PIX_W-1:0]  pixel;
        logic [DST_AW-1:0] col;
        logic [DST_AW-1:0] row;
    } resize_pixel_t;

    // predictor state: stored frame and raw size registers
    logic [PIX_W-1:0]  frame_mem [MAX_SRC_DIM*MAX_SRC_DIM];
    bit                frame_loaded [MAX_SRC_DIM*MAX_SRC_DIM];
    logic [8:0]        reg_sw, reg_sh;
    logic [12:0]       reg_dw, reg_dh;

    resize_pixel_t     pending_pixels [$];
    int                fail_count;
    int                cycle_count;
    int                loads_sent, requests_sent, results_seen;
    bit                no_gaps;

    bilinear_image_resize u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .src_col   (src_col),
        .src_row   (src_row),
        .src_pixel (src_pixel),
        .dst_col   (dst_col),
        .dst_row   (dst_row),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_pixel (out_pixel),
        .out_col   (out_col),
        .out_row   (out_row)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // effective size after zero and saturation handling
    function automatic longint eff_size(input longint v, input longint maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    // fixed-point source coordinate of one axis
    function automatic longint map_axis(input longint d, input longint ssize,
                                        input longint dsize);
        if (dsize <= 1)
            return 0;
        if (d > dsize - 1)
            d = dsize - 1;
        return ((ssize - 1) << FRAC_BITS) * d / (dsize - 1);
    endfunction

    // the four neighbour indexes and fractions of a destination pixel
    function automatic void neighbours(input logic [DST_AW-1:0] dc, input logic [DST_AW-1:0] dr,
                                       output longint x1, output longint x2,
                                       output longint y1, output longint y2,
                                       output longint fx, output longint fy);
        longint sw, sh, rx, ry;
        sw = eff_size(longint'(reg_sw), MAX_SRC_DIM);
        sh = eff_size(longint'(reg_sh), MAX_SRC_DIM);
        rx = map_axis(longint'(dc), sw, eff_size(longint'(reg_dw), MAX_DST_DIM));
        ry = map_axis(longint'(dr), sh, eff_size(longint'(reg_dh), MAX_DST_DIM));
        x1 = rx >> FRAC_BITS;
        y1 = ry >> FRAC_BITS;
        fx = rx & ((64'd1 << FRAC_BITS) - 1);
        fy = ry & ((64'd1 << FRAC_BITS) - 1);
        if (x1 > sw - 1)
            x1 = sw - 1;
        if (y1 > sh - 1)
            y1 = sh - 1;
        x2 = (x1 + 1 >= sw) ? sw - 1 : x1 + 1;
        y2 = (y1 + 1 >= sh) ? sh - 1 : y1 + 1;
    endfunction

    // bilinear blend of a destination pixel, rounded half up and clamped
    function automatic logic [PIX_W-1:0] blend_pixel(input logic [DST_AW-1:0] dc,
                                                     input logic [DST_AW-1:0] dr);
        longint x1, x2, y1, y2, fx, fy, one, acc, v;
        neighbours(dc, dr, x1, x2, y1, y2, fx, fy);
        one = 64'd1 << FRAC_BITS;
        acc = (one - fx) * (one - fy) * frame_mem[y1*MAX_SRC_DIM + x1]
            + fx * (one - fy) * frame_mem[y1*MAX_SRC_DIM + x2]
            + (one - fx) * fy * frame_mem[y2*MAX_SRC_DIM + x1]
            + fx * fy * frame_mem[y2*MAX_SRC_DIM + x2];
        v = (acc + (64'd1 << (2*FRAC_BITS - 1))) >> (2*FRAC_BITS);
        if (v > 255)
            v = 255;
        return v[PIX_W-1:0];
    endfunction

    // drive one transaction and update the predictor when it is taken
    task automatic send_item(input logic m, input logic [SRC_AW-1:0] sc,
                             input logic [SRC_AW-1:0] sr, input logic [PIX_W-1:0] sp,
                             input logic [DST_AW-1:0] dc, input logic [DST_AW-1:0] dr);
        int gap;
        resize_pixel_t exp_pix;
        gap = no_gaps ? 0 : int'($urandom_range(0, 14));
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start     = 1'b1;
        mode      = m;
        src_col   = sc;
        src_row   = sr;
        src_pixel = sp;
        dst_col   = dc;
        dst_row   = dr;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if (m == bir_pkg::MODE_LOAD)
        begin
            frame_mem[sr*MAX_SRC_DIM + sc]    = sp;
            frame_loaded[sr*MAX_SRC_DIM + sc] = 1'b1;
            loads_sent++;
        end
        else
        begin
            exp_pix.pixel = blend_pixel(dc, dr);
            exp_pix.col   = dc;
            exp_pix.row   = dr;
            pending_pixels.push_back(exp_pix);
            requests_sent++;
        end
    endtask

    // load any unloaded neighbour first, then request the pixel
    task automatic request_pixel(input logic [DST_AW-1:0] dc, input logic [DST_AW-1:0] dr);
        longint x1, x2, y1, y2, fx, fy;
        longint xs [2];
        longint ys [2];
        neighbours(dc, dr, x1, x2, y1, y2, fx, fy);
        xs[0] = x1; xs[1] = x2; ys[0] = y1; ys[1] = y2;
        foreach (ys[j])
            foreach (xs[i])
                if (!frame_loaded[ys[j]*MAX_SRC_DIM + xs[i]])
                    send_item(bir_pkg::MODE_LOAD, SRC_AW'(xs[i]), SRC_AW'(ys[j]),
                              PIX_W'($urandom_range(0, 255)), '0, '0);
        send_item(bir_pkg::MODE_REQ, SRC_AW'($urandom), SRC_AW'($urandom),
                  PIX_W'($urandom), dc, dr);
    endtask

    // wait until every expected result has come and the pipeline has emptied
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(input bir_pkg::cfg_reg_t idx, input logic [CFG_DW-1:0] val);
        drain_results();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            bir_pkg::REG_SRC_WIDTH:  reg_sw = val[8:0];
            bir_pkg::REG_SRC_HEIGHT: reg_sh = val[8:0];
            bir_pkg::REG_DST_WIDTH:  reg_dw = val[12:0];
            bir_pkg::REG_DST_HEIGHT: reg_dh = val[12:0];
            default: ;
        endcase
    endtask

    task automatic set_sizes(input logic [CFG_DW-1:0] sw, input logic [CFG_DW-1:0] sh,
                             input logic [CFG_DW-1:0] dw, input logic [CFG_DW-1:0] dh);
        write_reg(bir_pkg::REG_SRC_WIDTH, sw);
        write_reg(bir_pkg::REG_SRC_HEIGHT, sh);
        write_reg(bir_pkg::REG_DST_WIDTH, dw);
        write_reg(bir_pkg::REG_DST_HEIGHT, dh);
    endtask

    // result checker
    always @(posedge clk)
    begin
        resize_pixel_t exp_pix;
        if (rst_n && out_valid)
        begin
            results_seen++;
            if (pending_pixels.size() == 0)
            begin
                $error("result with nothing expected: col %0d row %0d", out_col, out_row);
                fail_count++;
            end
            else
            begin
                exp_pix = pending_pixels.pop_front();
                if (out_pixel !== exp_pix.pixel)
                begin
                    $error("out_pixel expected %0d actual %0d", exp_pix.pixel, out_pixel);
                    fail_count++;
                end
                if (out_col !== exp_pix.col)
                begin
                    $error("out_col expected %0d actual %0d", exp_pix.col, out_col);
                    fail_count++;
                end
                if (out_row !== exp_pix.row)
                begin
                    $error("out_row expected %0d actual %0d", exp_pix.row, out_row);
                    fail_count++;
                end
            end
        end
    end

    // corners and extreme pixel values under the reset sizes
    task automatic test_reset_sizes();
        send_item(bir_pkg::MODE_LOAD, 8'd0, 8'd0, 8'd255, 12'd0, 12'd0);
        send_item(bir_pkg::MODE_LOAD, 8'd1, 8'd0, 8'd0, 12'd0, 12'd0);
        send_item(bir_pkg::MODE_LOAD, 8'd255, 8'd255, 8'd255, 12'd0, 12'd0);
        request_pixel(12'd0, 12'd0);
        request_pixel(12'd255, 12'd255);
        request_pixel(12'd128, 12'd64);
        // beyond the destination size: interpolation saturates, echo does not
        request_pixel(12'hFFF, 12'hFFF);
    endtask

    // size extremes: single pixel, zero, oversized, largest destination
    task automatic test_size_extremes();
        set_sizes(13'd1, 13'd1, 13'd1, 13'd1);
        request_pixel(12'd0, 12'd0);
        request_pixel(12'hABC, 12'h543);
        set_sizes(13'd0, 13'd0, 13'd0, 13'd0);
        request_pixel(12'd7, 12'd3);
        set_sizes(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
        request_pixel(12'd4095, 12'd4095);
        request_pixel(12'd2047, 12'd1);
        request_pixel(12'd4094, 12'd2);
        set_sizes(13'd2, 13'd2, 13'd3, 13'd3);
        request_pixel(12'd1, 12'd1);
        request_pixel(12'd2, 12'd0);
        set_sizes(13'd256, 13'd256, 13'd2, 13'd4096);
        request_pixel(12'd0, 12'd4095);
        request_pixel(12'd1, 12'd1234);
        // hold off until the pipeline is empty, then go on
        drain_results();
        request_pixel(12'd1, 12'd0);
    endtask

    function automatic logic [CFG_DW-1:0] pick_src_size();
        int sel;
        sel = int'($urandom_range(0, 19));
        if (sel == 0)
            return 13'd0;
        if (sel == 1)
            return 13'd256;
        if (sel == 2)
            return CFG_DW'($urandom_range(257, 8191));
        if (sel < 6)
            return CFG_DW'($urandom_range(1, 256));
        return CFG_DW'($urandom_range(1, 16));
    endfunction

    function automatic logic [CFG_DW-1:0] pick_dst_size();
        int sel;
        sel = int'($urandom_range(0, 19));
        if (sel == 0)
            return 13'd0;
        if (sel == 1)
            return 13'd4096;
        if (sel == 2)
            return CFG_DW'($urandom_range(4097, 8191));
        if (sel < 6)
            return CFG_DW'($urandom_range(1, 4096));
        return CFG_DW'($urandom_range(1, 64));
    endfunction

    // random phases: mostly in-range requests, some beyond, some stray loads
    task automatic test_random_phases();
        int kind;
        longint dwe, dhe;
        for (int phase = 0; phase < 15; phase++)
        begin
            set_sizes(pick_src_size(), pick_src_size(), pick_dst_size(), pick_dst_size());
            dwe = eff_size(longint'(reg_dw), MAX_DST_DIM);
            dhe = eff_size(longint'(reg_dh), MAX_DST_DIM);
            no_gaps = (phase % 5 == 2);
            for (int n = 0; n < 80; n++)
            begin
                kind = int'($urandom_range(0, 9));
                if (kind < 7)
                    request_pixel(DST_AW'($urandom_range(0, dwe - 1)),
                                  DST_AW'($urandom_range(0, dhe - 1)));
                else if (kind < 9)
                    send_item(bir_pkg::MODE_LOAD, SRC_AW'($urandom), SRC_AW'($urandom),
                              PIX_W'($urandom), DST_AW'($urandom), DST_AW'($urandom));
                else
                    request_pixel(DST_AW'($urandom), DST_AW'($urandom));
            end
            no_gaps = 1'b0;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        mode      = bir_pkg::MODE_LOAD;
        src_col   = '0;
        src_row   = '0;
        src_pixel = '0;
        dst_col   = '0;
        dst_row   = '0;
        cfg_we    = 1'b0;
        cfg_index = bir_pkg::REG_SRC_WIDTH;
        cfg_data  = '0;
        reg_sw = 9'd256; reg_sh = 9'd256; reg_dw = 13'd256; reg_dh = 13'd256;
        fail_count = 0; cycle_count = 0;
        loads_sent = 0; requests_sent = 0; results_seen = 0;
        no_gaps = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_reset_sizes();
        test_size_extremes();
        test_random_phases();
        drain_results();

        $display("run covered %0d loads and %0d requests, %0d results checked",
                 loads_sent, requests_sent, results_seen);
        $display("size registers swept through zero, one, maximum and oversized values");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
